// ===== rtl/salsa_variant_stream_cipher_top_macros.svh =====
// Assertion macros shared by the stream cipher RTL.
`ifndef SALSA_VARIANT_STREAM_CIPHER_TOP_MACROS_SVH
`define SALSA_VARIANT_STREAM_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SVSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SVSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/svsc_pkg.sv =====
// Types and constants for the Salsa-layout stream cipher.
package svsc_pkg;

    typedef logic [31:0] word_t;
    typedef logic [3:0][31:0] col_t;

    // Block layout constants
    localparam word_t C_WORD0     = 32'h61707865;
    localparam word_t C_WORD1_128 = 32'h3120646e;
    localparam word_t C_WORD1_256 = 32'h3320646e;
    localparam word_t C_WORD2_128 = 32'h79622d36;
    localparam word_t C_WORD2_256 = 32'h79622d32;
    localparam word_t C_WORD3     = 32'h6b206574;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY0     = 3'd0;
    localparam logic [2:0] REG_KEY1     = 3'd1;
    localparam logic [2:0] REG_KEY2     = 3'd2;
    localparam logic [2:0] REG_KEY3     = 3'd3;
    localparam logic [2:0] REG_NONCE    = 3'd4;
    localparam logic [2:0] REG_KEY_SIZE = 3'd5;

    // Mix step codes within one quarter round
    localparam logic [1:0] STEP_ROT16 = 2'd0;
    localparam logic [1:0] STEP_ROT12 = 2'd1;
    localparam logic [1:0] STEP_ROT8  = 2'd2;
    localparam logic [1:0] STEP_ROT7  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_WRITE,
        ST_READ,
        ST_DATA
    } state_t;

endpackage

// ===== rtl/salsa_variant_stream_cipher_top.sv =====
// Salsa-layout stream cipher: XORs each byte with its keystream byte.
//
// Each item is XORed with byte (stream_pos mod 64) of the keystream block
// numbered stream_pos / 64. The last block is held in a 16 x 32-bit keystream
// RAM. An item whose block is already held has its RAM word read as it is
// accepted, then its result is loaded into the output register. An item that
// needs a new block runs one mix step per cycle on the two active columns for
// each double round, then writes the 16 fed-forward words through the single
// RAM write port, then does one RAM read. A new item is not accepted until the
// last one has been loaded. Any write to a defined configuration register drops
// the held block. The result waits in an output register, so a new item is
// accepted while an earlier result is still stalled.
`include "salsa_variant_stream_cipher_top_macros.svh"

module salsa_variant_stream_cipher_top
    import svsc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic [31:0] stream_pos,
    input  logic        last_byte,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_out,
    output logic        last_out
);

    localparam int RND_W = $clog2(DOUBLE_ROUNDS + 1);

    // configuration registers
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg;
    logic        key_size_reg;

    // control
    state_t      state_reg, state_next;
    logic [1:0]  step_reg;
    logic [RND_W-1:0] round_reg;
    logic [3:0]  widx_reg;
    logic        cache_valid_reg;
    logic [25:0] cached_block_reg;

    // held item
    logic [31:0] pos_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    // working columns: words 0,4,8,12 and 1,5,9,13
    col_t        col_a_reg, col_b_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  byte_out_reg;
    logic        last_out_reg;

    // keystream RAM
    word_t       ks_mem [16];
    word_t       rd_data_reg;

    logic        in_acc, cfg_acc, cfg_hit;
    logic        hit, out_free, rnd_last;
    logic        mem_we, mem_re, out_load;
    logic [3:0]  raddr;
    word_t       wdata;
    logic [25:0] blk_sel;
    logic [63:0] hi0, hi1;
    word_t       init_w [16];
    logic [7:0]  ks_byte;

    // one add-xor-rotate step on a column {a,b,c,d}
    function automatic col_t mix_col(input col_t w, input logic [1:0] step);
        col_t  r;
        word_t s;
        word_t x;
        r = w;
        s = '0;
        x = '0;
        case (step)
            STEP_ROT16:
            begin
                s = w[0] + w[1];
                x = w[3] ^ s;
                r[0] = s;
                r[3] = {x[15:0], x[31:16]};
            end
            STEP_ROT12:
            begin
                s = w[2] + w[3];
                x = w[1] ^ s;
                r[2] = s;
                r[1] = {x[19:0], x[31:20]};
            end
            STEP_ROT8:
            begin
                s = w[0] + w[1];
                x = w[3] ^ s;
                r[0] = s;
                r[3] = {x[23:0], x[31:24]};
            end
            STEP_ROT7:
            begin
                s = w[2] + w[3];
                x = w[1] ^ s;
                r[2] = s;
                r[1] = {x[24:0], x[31:25]};
            end
            default:
            begin
                r = w;
            end
        endcase
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_hit   = (cfg_index == REG_KEY0) || (cfg_index == REG_KEY1) ||
                       (cfg_index == REG_KEY2) || (cfg_index == REG_KEY3) ||
                       (cfg_index == REG_NONCE) || (cfg_index == REG_KEY_SIZE);

    assign in_acc   = in_valid && !in_stall;
    assign hit      = cache_valid_reg && (cached_block_reg == stream_pos[31:6]);
    assign out_free = !out_valid_reg || !out_stall;
    assign rnd_last = (round_reg == RND_W'(DOUBLE_ROUNDS - 1));

    // initial block words
    assign blk_sel = (state_reg == ST_IDLE) ? stream_pos[31:6] : pos_reg[31:6];
    assign hi0     = key_size_reg ? key2_reg : key0_reg;
    assign hi1     = key_size_reg ? key3_reg : key1_reg;

    always_comb
    begin
        init_w[0]  = C_WORD0;
        init_w[1]  = key0_reg[31:0];
        init_w[2]  = key0_reg[63:32];
        init_w[3]  = key1_reg[31:0];
        init_w[4]  = key1_reg[63:32];
        init_w[5]  = key_size_reg ? C_WORD1_256 : C_WORD1_128;
        init_w[6]  = nonce_reg[31:0];
        init_w[7]  = nonce_reg[63:32];
        init_w[8]  = {6'd0, blk_sel};
        init_w[9]  = '0;
        init_w[10] = key_size_reg ? C_WORD2_256 : C_WORD2_128;
        init_w[11] = hi0[31:0];
        init_w[12] = hi0[63:32];
        init_w[13] = hi1[31:0];
        init_w[14] = hi1[63:32];
        init_w[15] = C_WORD3;
    end

    // feed-forward word for the RAM write
    always_comb
    begin
        case (widx_reg[1:0])
            2'd0:    wdata = col_a_reg[widx_reg[3:2]] + init_w[widx_reg];
            2'd1:    wdata = col_b_reg[widx_reg[3:2]] + init_w[widx_reg];
            default: wdata = init_w[widx_reg] + init_w[widx_reg];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = hit ? ST_DATA : ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (step_reg == STEP_ROT7 && rnd_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (widx_reg == 4'd15)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall = 1'b1;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        raddr    = pos_reg[5:2];
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                mem_re   = in_valid;
                raddr    = stream_pos[5:2];
            end
            ST_ROUND:
            begin
                in_stall = 1'b1;
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_DATA:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_reg    <= '0;
            key_size_reg <= 1'b1;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                REG_KEY0:     key0_reg     <= cfg_data;
                REG_KEY1:     key1_reg     <= cfg_data;
                REG_KEY2:     key2_reg     <= cfg_data;
                REG_KEY3:     key3_reg     <= cfg_data;
                REG_NONCE:    nonce_reg    <= cfg_data;
                REG_KEY_SIZE: key_size_reg <= cfg_data[0];
                default:      key_size_reg <= key_size_reg;
            endcase
        end
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_ROT16;
            round_reg        <= '0;
            widx_reg         <= '0;
            cache_valid_reg  <= 1'b0;
            cached_block_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                step_reg  <= STEP_ROT16;
                round_reg <= '0;
                widx_reg  <= '0;
            end
            else if (state_reg == ST_ROUND)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == STEP_ROT7)
                begin
                    round_reg <= round_reg + RND_W'(1);
                end
            end
            else if (state_reg == ST_WRITE)
            begin
                widx_reg <= widx_reg + 4'd1;
            end

            // block cache tag
            if (cfg_acc && cfg_hit)
            begin
                cache_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_WRITE && widx_reg == 4'd15)
            begin
                cache_valid_reg  <= 1'b1;
                cached_block_reg <= pos_reg[31:6];
            end

            // output handshake
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // held item and working columns
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pos_reg   <= stream_pos;
            byte_reg  <= byte_in;
            last_reg  <= last_byte;
            col_a_reg <= {init_w[12], init_w[8], init_w[4], init_w[0]};
            col_b_reg <= {init_w[13], init_w[9], init_w[5], init_w[1]};
        end
        else if (state_reg == ST_ROUND)
        begin
            col_a_reg <= mix_col(col_a_reg, step_reg);
            col_b_reg <= mix_col(col_b_reg, step_reg);
        end
    end

    // keystream RAM, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ks_mem[widx_reg] <= wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= ks_mem[raddr];
        end
    end

    // byte select and output payload
    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    ks_byte = rd_data_reg[7:0];
            2'd1:    ks_byte = rd_data_reg[15:8];
            2'd2:    ks_byte = rd_data_reg[23:16];
            default: ks_byte = rd_data_reg[31:24];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            byte_out_reg <= byte_reg ^ ks_byte;
            last_out_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = byte_out_reg;
    assign last_out  = last_out_reg;

    // checks
    `SVSC_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_reg != ST_IDLE,
        "accepted item did not start processing")
    `SVSC_ASSERT_NOW(a_read_hits_cache, state_reg == ST_READ,
        cache_valid_reg && (cached_block_reg == pos_reg[31:6]),
        "keystream read without a matching cached block")
    `SVSC_ASSERT_NEXT(a_rounds_then_write,
        (state_reg == ST_ROUND) && (step_reg == STEP_ROT7) && rnd_last,
        state_reg == ST_WRITE, "round phase did not end in the write phase")
    `SVSC_ASSERT_NOW(a_result_from_data, $rose(out_valid_reg),
        $past(state_reg == ST_DATA), "result raised outside the data state")

endmodule
